FILE: hw/rtl/s2ptb_pkg.sv
// types, constants and the microcode rom of the stage-2 table builder
// used by s2ptb_useq, s2ptb_dpath and the core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package s2ptb_pkg;

    localparam int SLOT_W   = 9;    // 512 entries per table
    localparam int PAGE_W   = 36;
    localparam int OFS_W    = 12;
    localparam int PADDR_W  = 48;
    localparam int ROOT_W   = 6;
    localparam int IA_W     = 27;
    localparam int STATUS_W = 2;

    localparam logic [OFS_W-1:0] DESC_TABLE = 12'h003;
    localparam logic [OFS_W-1:0] DESC_PAGE  = 12'h4D3;  // af, rw, normal memory, page

    localparam logic [STATUS_W-1:0] ST_DESC = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ROOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;

    typedef struct packed {
        logic              action;
        logic [ROOT_W-1:0] root_table;
        logic [IA_W-1:0]   ia_page;
        logic [PAGE_W-1:0] oa_page;
        logic              last_page;
    } in_item_t;

    typedef struct packed {
        logic [PADDR_W-1:0]  write_addr;
        logic [PADDR_W-1:0]  write_data;
        logic [STATUS_W-1:0] status;
        logic                range_done;
        logic                last;
    } out_item_t;

    typedef enum logic [3:0] {
        STEP_IDLE     = 4'd0,
        STEP_CHK_FAIL = 4'd1,
        STEP_CHK_KIND = 4'd2,
        STEP_RD_ENTRY = 4'd3,
        STEP_RD_BACK  = 4'd4,
        STEP_CHK_HIT  = 4'd5,
        STEP_CHK_POOL = 4'd6,
        STEP_LINK     = 4'd7,
        STEP_FOLLOW   = 4'd8,
        STEP_PAGE     = 4'd9,
        STEP_ROOT_CHK = 4'd10,
        STEP_ROOT     = 4'd11,
        STEP_SET_FAIL = 4'd12,
        STEP_FAIL     = 4'd13
    } step_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_BAD,
        C_ALLOC,
        C_HIT,
        C_FULL,
        C_LVL_FIRST
    } cond_t;

    typedef enum logic [1:0] {
        E_TABLE,
        E_PAGE,
        E_ROOT,
        E_FAIL
    } emit_kind_t;

    typedef struct packed {
        logic       accept;
        cond_t      cond;
        step_t      target;
        logic       rd_entry;
        logic       rd_back;
        logic       link;
        logic       alloc_root;
        logic       set_fail;
        logic       follow;
        logic       emit;
        emit_kind_t kind;
        logic       emit_last;
    } ctrl_t;

    // control word plus the go signal that qualifies every side effect
    typedef struct packed {
        ctrl_t word;
        logic  fire;
    } useq_t;

    typedef struct packed {
        logic item_valid;
        logic bad;
        logic alloc;
        logic hit;
        logic full;
        logic lvl_first;
        logic out_free;
    } flags_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w        = '0;
        w.cond   = C_NEVER;
        w.target = STEP_IDLE;
        w.kind   = E_FAIL;
        case (step)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = C_NO_ITEM;
                w.target = STEP_IDLE;
            end
            STEP_CHK_FAIL:
            begin
                w.cond   = C_BAD;
                w.target = STEP_FAIL;
            end
            STEP_CHK_KIND:
            begin
                w.cond   = C_ALLOC;
                w.target = STEP_ROOT_CHK;
            end
            STEP_RD_ENTRY:
            begin
                w.rd_entry = 1'b1;
            end
            STEP_RD_BACK:
            begin
                w.rd_back = 1'b1;
            end
            STEP_CHK_HIT:
            begin
                w.cond   = C_HIT;
                w.target = STEP_FOLLOW;
            end
            STEP_CHK_POOL:
            begin
                w.cond   = C_FULL;
                w.target = STEP_SET_FAIL;
            end
            STEP_LINK:
            begin
                w.link = 1'b1;
                w.emit = 1'b1;
                w.kind = E_TABLE;
            end
            STEP_FOLLOW:
            begin
                w.follow = 1'b1;
                w.cond   = C_LVL_FIRST;
                w.target = STEP_RD_ENTRY;
            end
            STEP_PAGE:
            begin
                w.emit      = 1'b1;
                w.kind      = E_PAGE;
                w.emit_last = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = STEP_IDLE;
            end
            STEP_ROOT_CHK:
            begin
                w.cond   = C_FULL;
                w.target = STEP_SET_FAIL;
            end
            STEP_ROOT:
            begin
                w.alloc_root = 1'b1;
                w.emit       = 1'b1;
                w.kind       = E_ROOT;
                w.emit_last  = 1'b1;
                w.cond       = C_ALWAYS;
                w.target     = STEP_IDLE;
            end
            STEP_SET_FAIL:
            begin
                w.set_fail = 1'b1;
            end
            STEP_FAIL:
            begin
                w.emit      = 1'b1;
                w.kind      = E_FAIL;
                w.emit_last = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = STEP_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/s2ptb_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module s2ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/s2ptb_useq.sv
// microcode sequencer: step counter, control rom and conditional jumps
// depends on s2ptb_pkg
`timescale 1ns / 1ps
`default_nettype none

module s2ptb_useq
    import s2ptb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output useq_t       useq
);

    step_t step_reg;
    step_t step_next;
    ctrl_t word;
    logic  hold;
    logic  taken;

    always_comb
    begin
        word = ucode_rom(step_reg);
        // an emitting step waits for room in the output register
        hold = word.emit && !flags.out_free;
        case (word.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_ITEM:   taken = !flags.item_valid;
            C_BAD:       taken = flags.bad;
            C_ALLOC:     taken = flags.alloc;
            C_HIT:       taken = flags.hit;
            C_FULL:      taken = flags.full;
            C_LVL_FIRST: taken = flags.lvl_first;
            default:     taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    always_comb
    begin
        useq.word = word;
        useq.fire = !hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/s2ptb_dpath.sv
// datapath: item and walk registers, entry and back-link rams, output register
// depends on s2ptb_pkg and s2ptb_ram
`timescale 1ns / 1ps
`default_nettype none

module s2ptb_dpath
    import s2ptb_pkg::*;
#(
    parameter int NUM_TABLES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire useq_t             useq,
    output flags_t                 flags,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [PAGE_W-1:0] cfg_data
);

    localparam int TIDX_W  = $clog2(NUM_TABLES);
    localparam int EADDR_W = TIDX_W + SLOT_W;
    localparam int BACK_W  = 1 + TIDX_W + SLOT_W;
    localparam int CMP_W   = 13;

    in_item_t            item_reg;
    logic [TIDX_W-1:0]   table_reg;
    logic [TIDX_W-1:0]   table_next;
    logic [TIDX_W-1:0]   child_reg;
    logic [TIDX_W-1:0]   child_next;
    logic                lt_reg;
    logic                lt_next;
    logic                lvl_reg;
    logic                lvl_next;
    logic [TIDX_W-1:0]   next_free_reg;
    logic [TIDX_W-1:0]   next_free_next;
    logic                failed_reg;
    logic                failed_next;
    logic [PAGE_W-1:0]   pool_base_reg;
    logic [PAGE_W-1:0]   pool_base_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_reg;
    out_item_t           emit_item;

    ctrl_t               w;
    logic                accept;
    logic                out_free;
    logic [SLOT_W-1:0]   slot;
    logic [PAGE_W-1:0]   tbl_page;
    logic [PAGE_W-1:0]   new_page;
    logic [CMP_W-1:0]    root_wide;
    logic                full;
    logic                entry_wr;
    logic [TIDX_W-1:0]   entry_rd;
    logic                back_wr;
    logic [BACK_W-1:0]   back_wr_data;
    logic [BACK_W-1:0]   back_rd;

    assign w         = useq.word;
    assign accept    = w.accept && in_valid;
    assign in_stall  = !w.accept;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign slot      = lvl_reg ? item_reg.ia_page[17:9] : item_reg.ia_page[26:18];
    assign tbl_page  = pool_base_reg + PAGE_W'(table_reg);
    assign new_page  = pool_base_reg + PAGE_W'(next_free_reg);
    assign root_wide = CMP_W'(item_reg.root_table);
    assign full      = next_free_reg >= TIDX_W'(NUM_TABLES - 1);

    // a link entry counts only if its child is allocated and points back at it
    always_comb
    begin
        flags.item_valid = in_valid;
        flags.bad        = failed_reg
                           || (item_reg.action != ACT_ALLOC
                               && root_wide >= CMP_W'(NUM_TABLES));
        flags.alloc      = item_reg.action == ACT_ALLOC;
        flags.hit        = lt_reg && back_rd == {1'b1, table_reg, slot};
        flags.full       = full;
        flags.lvl_first  = !lvl_reg;
        flags.out_free   = out_free;
    end

    assign entry_wr     = useq.fire && w.link;
    assign back_wr      = useq.fire && (w.link || w.alloc_root);
    assign back_wr_data = w.link ? {1'b1, table_reg, slot} : '0;

    s2ptb_ram #(
        .WIDTH (TIDX_W),
        .DEPTH (NUM_TABLES * (2 ** SLOT_W))
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_wr),
        .wr_addr (EADDR_W'({table_reg, slot})),
        .wr_data (next_free_reg),
        .rd_en   (useq.fire && w.rd_entry),
        .rd_addr (EADDR_W'({table_reg, slot})),
        .rd_data (entry_rd)
    );

    s2ptb_ram #(
        .WIDTH (BACK_W),
        .DEPTH (NUM_TABLES)
    ) u_back_ram (
        .clk     (clk),
        .wr_en   (back_wr),
        .wr_addr (next_free_reg),
        .wr_data (back_wr_data),
        .rd_en   (useq.fire && w.rd_back),
        .rd_addr (entry_rd),
        .rd_data (back_rd)
    );

    always_comb
    begin
        emit_item = '0;
        case (w.kind)
            E_TABLE:
            begin
                emit_item.write_addr = {tbl_page, slot, 3'b000};
                emit_item.write_data = {new_page, DESC_TABLE};
                emit_item.status     = ST_DESC;
            end
            E_PAGE:
            begin
                emit_item.write_addr = {tbl_page, item_reg.ia_page[8:0], 3'b000};
                emit_item.write_data = {item_reg.oa_page, DESC_PAGE};
                emit_item.status     = ST_DESC;
            end
            E_ROOT:
            begin
                emit_item.write_addr = {new_page, OFS_W'(0)};
                emit_item.status     = ST_ROOT;
            end
            E_FAIL:
            begin
                emit_item.status     = ST_FAIL;
            end
            default:
            begin
                emit_item.status     = ST_FAIL;
            end
        endcase
        emit_item.range_done = w.emit_last && item_reg.last_page;
        emit_item.last       = w.emit_last;
    end

    always_comb
    begin
        table_next     = table_reg;
        child_next     = child_reg;
        lt_next        = lt_reg;
        lvl_next       = lvl_reg;
        next_free_next = next_free_reg;
        failed_next    = failed_reg;
        pool_base_next = pool_base_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid)
        begin
            pool_base_next = cfg_data;
        end
        if (accept)
        begin
            table_next = TIDX_W'(in_data.root_table);
            lvl_next   = 1'b0;
        end
        if (useq.fire)
        begin
            if (w.rd_back)
            begin
                child_next = entry_rd;
                lt_next    = entry_rd < next_free_reg;
            end
            if (w.link)
            begin
                child_next = next_free_reg;
            end
            if (w.link || w.alloc_root)
            begin
                next_free_next = next_free_reg + TIDX_W'(1);
            end
            if (w.follow)
            begin
                table_next = child_reg;
                lvl_next   = 1'b1;
            end
            if (w.set_fail)
            begin
                failed_next = 1'b1;
            end
        end

        if (useq.fire && w.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg       <= 1'b0;
            next_free_reg <= '0;
            failed_reg    <= 1'b0;
            pool_base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lvl_reg       <= lvl_next;
            next_free_reg <= next_free_next;
            failed_reg    <= failed_next;
            pool_base_reg <= pool_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        table_reg <= table_next;
        child_reg <= child_next;
        lt_reg    <= lt_next;
        if (useq.fire && w.emit)
        begin
            out_reg <= emit_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stage2_page_table_builder_core.sv
// handles allocate, rejected and map items one at a time, stepping through the
// microcode sequence with two registered reads per level and linking any table
// missing on the way; a stalled result holds
// reset clears the step counter, level, free pointer, sticky error, pool base and
// output valid; table memory is not cleared, stale links fail the back-pointer check
// depends on s2ptb_pkg, s2ptb_useq, s2ptb_dpath
`timescale 1ns / 1ps
`default_nettype none

module stage2_page_table_builder_core
    import s2ptb_pkg::*;
#(
    parameter int NUM_TABLES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [PAGE_W-1:0] cfg_data
);

    useq_t  useq;
    flags_t flags;

    s2ptb_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .useq  (useq)
    );

    s2ptb_dpath #(
        .NUM_TABLES (NUM_TABLES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .useq      (useq),
        .flags     (flags),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
